### rtl/core/icalc_pkg.sv
package icalc_pkg;

    // width that results wrap to before sign extension onto the 32-bit port
    localparam int DATA_WIDTH = 32;

    localparam int XLEN       = 32;
    localparam int OPND_W     = 31;
    localparam int MODE_W     = 3;
    localparam int UPC_W      = 4;
    localparam int CNT_W      = 5;
    localparam int DIV_STEPS  = OPND_W;
    localparam int SQRT_STEPS = (OPND_W + 1) / 2;
    localparam int WRAP_SH    = (DATA_WIDTH >= XLEN) ? 0 : XLEN - DATA_WIDTH;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_DIV  = 3'd3,
        MODE_SQRT = 3'd4,
        MODE_POW  = 3'd5
    } t_mode;

    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_ADD,
        UOP_SUB,
        UOP_MUL,
        UOP_ZERO,
        UOP_DIV_INIT,
        UOP_DIV_STEP,
        UOP_SQRT_INIT,
        UOP_SQRT_STEP,
        UOP_POW_INIT,
        UOP_POW_MUL,
        UOP_POW_SQ
    } t_uop;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_END,
        SEQ_LOOP
    } t_seq;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

    typedef struct packed {
        t_uop              uop;
        t_seq              seq;
        logic [UPC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic load;
        logic run;
        t_uop uop;
    } t_dp_ctl;

    localparam logic [UPC_W-1:0] UA_ADD       = 4'd0;
    localparam logic [UPC_W-1:0] UA_SUB       = 4'd1;
    localparam logic [UPC_W-1:0] UA_MUL       = 4'd2;
    localparam logic [UPC_W-1:0] UA_DIV_INIT  = 4'd3;
    localparam logic [UPC_W-1:0] UA_DIV_STEP  = 4'd4;
    localparam logic [UPC_W-1:0] UA_SQRT_INIT = 4'd5;
    localparam logic [UPC_W-1:0] UA_SQRT_STEP = 4'd6;
    localparam logic [UPC_W-1:0] UA_POW_INIT  = 4'd7;
    localparam logic [UPC_W-1:0] UA_POW_MUL   = 4'd8;
    localparam logic [UPC_W-1:0] UA_POW_SQ    = 4'd9;
    localparam logic [UPC_W-1:0] UA_ZERO      = 4'd10;

    function automatic t_uword ucode(logic [UPC_W-1:0] addr);
        t_uword w;
        w = '{uop: UOP_NOP, seq: SEQ_END, target: UA_ZERO};
        unique case (addr)
            UA_ADD:       w = '{uop: UOP_ADD,       seq: SEQ_END,  target: UA_ZERO};
            UA_SUB:       w = '{uop: UOP_SUB,       seq: SEQ_END,  target: UA_ZERO};
            UA_MUL:       w = '{uop: UOP_MUL,       seq: SEQ_END,  target: UA_ZERO};
            UA_DIV_INIT:  w = '{uop: UOP_DIV_INIT,  seq: SEQ_LOOP, target: UA_DIV_STEP};
            UA_DIV_STEP:  w = '{uop: UOP_DIV_STEP,  seq: SEQ_LOOP, target: UA_DIV_STEP};
            UA_SQRT_INIT: w = '{uop: UOP_SQRT_INIT, seq: SEQ_NEXT, target: UA_ZERO};
            UA_SQRT_STEP: w = '{uop: UOP_SQRT_STEP, seq: SEQ_LOOP, target: UA_SQRT_STEP};
            UA_POW_INIT:  w = '{uop: UOP_POW_INIT,  seq: SEQ_LOOP, target: UA_POW_MUL};
            UA_POW_MUL:   w = '{uop: UOP_POW_MUL,   seq: SEQ_NEXT, target: UA_ZERO};
            UA_POW_SQ:    w = '{uop: UOP_POW_SQ,    seq: SEQ_LOOP, target: UA_POW_MUL};
            UA_ZERO:      w = '{uop: UOP_ZERO,      seq: SEQ_END,  target: UA_ZERO};
            default:      w = '{uop: UOP_NOP,       seq: SEQ_END,  target: UA_ZERO};
        endcase
        return w;
    endfunction

    function automatic logic [UPC_W-1:0] entry_addr(logic [MODE_W-1:0] mode);
        logic [UPC_W-1:0] a;
        a = UA_ZERO;
        unique case (mode)
            MODE_ADD:  a = UA_ADD;
            MODE_SUB:  a = UA_SUB;
            MODE_MUL:  a = UA_MUL;
            MODE_DIV:  a = UA_DIV_INIT;
            MODE_SQRT: a = UA_SQRT_INIT;
            MODE_POW:  a = UA_POW_INIT;
            default:   a = UA_ZERO;
        endcase
        return a;
    endfunction

    // keep the low DATA_WIDTH bits and sign-extend them onto the port
    function automatic logic [XLEN-1:0] wrap_out(logic [XLEN-1:0] v);
        logic signed [XLEN-1:0] s;
        s = $signed(v << WRAP_SH);
        return XLEN'(s >>> WRAP_SH);
    endfunction

endpackage

### rtl/core/icalc_dpath.sv
module icalc_dpath
    import icalc_pkg::*;
(
    input  logic              i_clk,
    input  t_dp_ctl           i_ctl,
    input  logic [OPND_W-1:0] i_operand_a,
    input  logic [OPND_W-1:0] i_operand_b,
    output logic              o_more,
    output logic [XLEN-1:0]   o_result,
    output logic              o_div_by_zero
);

    logic [OPND_W-1:0] r_a, r_b;
    logic [XLEN-1:0]   r_acc, n_acc;   // result / quotient / root / power accumulator
    logic [XLEN-1:0]   r_aux, n_aux;   // remainder or running square
    logic [XLEN-1:0]   r_sh, n_sh;     // root bit or exponent
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_dz, n_dz;

    logic [XLEN-1:0]   a_ext, b_ext;
    logic [XLEN-1:0]   mul_x, mul_y;
    logic [XLEN-1:0]   prod;
    logic [XLEN-1:0]   div_rem;
    logic              div_ge;
    logic [XLEN-1:0]   sq_sum;
    logic              sq_ge;

    assign a_ext = {{(XLEN-OPND_W){1'b0}}, r_a};
    assign b_ext = {{(XLEN-OPND_W){1'b0}}, r_b};

    // one shared multiplier, low word kept
    always_comb begin
        unique case (i_ctl.uop)
            UOP_POW_MUL: begin
                mul_x = r_acc;
                mul_y = r_aux;
            end
            UOP_POW_SQ: begin
                mul_x = r_aux;
                mul_y = r_aux;
            end
            default: begin
                mul_x = a_ext;
                mul_y = b_ext;
            end
        endcase
    end
    assign prod = mul_x * mul_y;

    assign div_rem = {r_aux[XLEN-2:0], r_acc[OPND_W-1]};
    assign div_ge  = (div_rem >= b_ext);
    assign sq_sum  = r_acc + r_sh;
    assign sq_ge   = (r_aux >= sq_sum);

    always_comb begin
        n_acc  = r_acc;
        n_aux  = r_aux;
        n_sh   = r_sh;
        n_cnt  = r_cnt;
        n_dz   = r_dz;
        o_more = 1'b0;
        unique case (i_ctl.uop)
            UOP_ADD:  n_acc = a_ext + b_ext;
            UOP_SUB:  n_acc = a_ext - b_ext;
            UOP_MUL:  n_acc = prod;
            UOP_ZERO: n_acc = '0;
            UOP_DIV_INIT: begin
                n_acc  = a_ext;
                n_aux  = '0;
                n_cnt  = CNT_W'(DIV_STEPS);
                n_dz   = (r_b == '0);
                o_more = (r_b != '0);
            end
            UOP_DIV_STEP: begin
                // restoring step: shift in the next dividend bit
                n_aux  = div_ge ? (div_rem - b_ext) : div_rem;
                n_acc  = {1'b0, r_acc[OPND_W-2:0], div_ge};
                n_cnt  = r_cnt - CNT_W'(1);
                o_more = (r_cnt != CNT_W'(1));
            end
            UOP_SQRT_INIT: begin
                n_acc = '0;
                n_aux = a_ext;
                n_sh  = XLEN'(1) << (2 * (SQRT_STEPS - 1));
                n_cnt = CNT_W'(SQRT_STEPS);
            end
            UOP_SQRT_STEP: begin
                n_aux  = sq_ge ? (r_aux - sq_sum) : r_aux;
                n_acc  = sq_ge ? ((r_acc >> 1) + r_sh) : (r_acc >> 1);
                n_sh   = r_sh >> 2;
                n_cnt  = r_cnt - CNT_W'(1);
                o_more = (r_cnt != CNT_W'(1));
            end
            UOP_POW_INIT: begin
                n_acc  = XLEN'(1);
                n_aux  = a_ext;
                n_sh   = b_ext;
                o_more = (r_b != '0);
            end
            UOP_POW_MUL: begin
                if (r_sh[0]) begin
                    n_acc = prod;
                end
            end
            UOP_POW_SQ: begin
                n_aux  = prod;
                n_sh   = r_sh >> 1;
                o_more = (r_sh[XLEN-1:1] != '0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a  <= i_operand_a;
            r_b  <= i_operand_b;
            r_dz <= 1'b0;
        end else if (i_ctl.run) begin
            r_acc <= n_acc;
            r_aux <= n_aux;
            r_sh  <= n_sh;
            r_cnt <= n_cnt;
            r_dz  <= n_dz;
        end
    end

    assign o_result      = r_dz ? '0 : wrap_out(r_acc);
    assign o_div_by_zero = r_dz;

endmodule

### rtl/core/icalc_useq.sv
module icalc_useq
    import icalc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [MODE_W-1:0] i_mode,
    input  logic              i_more,
    input  logic              i_out_free,
    output logic              o_in_stall,
    output t_dp_ctl           o_ctl,
    output logic              o_out_load
);

    t_state           r_state, n_state;
    logic [UPC_W-1:0] r_upc, n_upc;
    t_uword           uw;

    assign uw = ucode(r_upc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_upc   <= UA_ZERO;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_upc      = r_upc;
        o_in_stall = 1'b1;
        o_out_load = 1'b0;
        o_ctl      = '{load: 1'b0, run: 1'b0, uop: UOP_NOP};
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_upc      = entry_addr(i_mode);
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                o_ctl.run = 1'b1;
                o_ctl.uop = uw.uop;
                unique case (uw.seq)
                    SEQ_NEXT: n_upc = r_upc + UPC_W'(1);
                    SEQ_END:  n_state = ST_HOLD;
                    SEQ_LOOP: begin
                        if (i_more) begin
                            n_upc = uw.target;
                        end else begin
                            n_state = ST_HOLD;
                        end
                    end
                    default:  n_state = ST_HOLD;
                endcase
            end
            ST_HOLD: begin
                // wait for the output register to free up
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

### rtl/core/integer_calculator_alu.sv
// integer calculator: add, subtract, multiply, floor divide, integer square
// root and power on two non-negative 31-bit operands, one result per beat.
// input channel: i_in_valid / o_in_stall with i_mode, i_operand_a, i_operand_b.
// output channel: o_out_valid / i_out_stall with o_result, o_div_by_zero.
// a small microcode table steps one shared datapath (one 32x32 multiplier
// plus adders and compares); steps per beat set the rate when unstalled:
//   add, sub, mul, unused mode: 1 step
//   divide: 32 steps (1 when the divisor is zero)
//   square root: 17 steps
//   power: 1 + 2 * (bit length of operand_b) steps, at most 63
// o_out_valid rises once the last step is done and the result has moved into
// the output register; a new beat is taken only once the previous one has
// moved into the output register, so beats never overlap.
// the output register holds a finished result while the receiver stalls;
// the next result waits behind it and the input stays stalled meanwhile.
// synchronous reset returns the sequencer to idle and empties the output
// register; no clearing pass is needed.
module integer_calculator_alu
    import icalc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic [OPND_W-1:0]        i_operand_a,
    input  logic [OPND_W-1:0]        i_operand_b,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [XLEN-1:0]   o_result,
    output logic                     o_div_by_zero
);

    t_dp_ctl          dp_ctl;
    logic             more;
    logic             out_load;
    logic             out_free;
    logic [XLEN-1:0]  dp_result;
    logic             dp_dz;

    logic             r_out_valid;
    logic [XLEN-1:0]  r_result;
    logic             r_dz;

    assign out_free = !r_out_valid || !i_out_stall;

    icalc_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_more     (more),
        .i_out_free (out_free),
        .o_in_stall (o_in_stall),
        .o_ctl      (dp_ctl),
        .o_out_load (out_load)
    );

    icalc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_ctl         (dp_ctl),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .o_more        (more),
        .o_result      (dp_result),
        .o_div_by_zero (dp_dz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_result <= dp_result;
            r_dz     <= dp_dz;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result      = $signed(r_result);
    assign o_div_by_zero = r_dz;

endmodule

### rtl/core/icalc_chk.sv
module icalc_chk
    import icalc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     o_in_stall,
    input  logic                     o_out_valid,
    input  logic                     i_out_stall,
    input  logic signed [XLEN-1:0]   o_result,
    input  logic                     o_div_by_zero
);

    // a divide-by-zero beat always carries a zero result
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_div_by_zero |-> o_result == '0)
        else $error("div_by_zero beat with nonzero result");

    // one beat in flight: input closes right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open the cycle after an accept");

    // no result appears in the cycle after an accept made while none shows
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> !o_out_valid)
        else $error("result without any work cycle");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_result) && $stable(o_div_by_zero))
        else $error("stalled output beat changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind integer_calculator_alu icalc_chk u_icalc_chk (.*);
